/* src/tfn_pkg.sv */
// shared types, widths and helpers for the triangle face normal core
package tfn_pkg;

   localparam int CoordWidth   = 24;
   localparam int OutFracBits  = 30;
   localparam int OutWidth     = 32;
   localparam int EdgeWidth    = CoordWidth + 1;
   localparam int ProdWidth    = 2 * EdgeWidth;
   localparam int CrossWidth   = ProdWidth;
   localparam int HalfWidth    = CrossWidth / 2;
   localparam int SqWidth      = 2 * CrossWidth + 2;
   localparam int QWidth       = OutFracBits + 1;
   // root of c^2 * 4^(F+1) / s, one bit per search stage
   localparam int RootWidth    = OutFracBits + 2;
   localparam int SearchSteps  = RootWidth;
   // scaled remainder stays below (8 * root + 4) * s
   localparam int RhoWidth     = SqWidth + RootWidth + 2;

   typedef logic signed [CoordWidth-1:0] coord_type;
   typedef logic signed [OutWidth-1:0]   norm_type;
   typedef logic [CrossWidth-1:0]        cmag_type;
   typedef logic [SqWidth-1:0]           sq_type;
   typedef logic [QWidth-1:0]            q_type;
   typedef logic [RootWidth-1:0]         root_type;
   typedef logic [RhoWidth-1:0]          rho_type;

   typedef struct packed {
      coord_type v0_x, v0_y, v0_z;
      coord_type v1_x, v1_y, v1_z;
      coord_type v2_x, v2_y, v2_z;
   } tri_type;

   typedef struct packed {
      norm_type norm_x, norm_y, norm_z;
      logic     degenerate;
   } nrm_type;

   // per-item bookkeeping that travels down the root search
   typedef struct packed {
      rho_type  [2:0] rho;
      rho_type  [2:0] acc;
      root_type [2:0] root;
      logic     [2:0] c_neg;
      sq_type         s;
      logic           degenerate;
   } srch_type;

endpackage

/* src/tfn_if.sv */
// valid/ready channel carrying one payload beat
interface tfn_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* src/tfn_cross.sv */
// front pipeline: edges, cross product, squared length (7 register stages)
module tfn_cross (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  tfn_pkg::tri_type    in_tri,
   output logic                out_valid,
   output tfn_pkg::srch_type   out_srch
);
   import tfn_pkg::*;

   typedef logic signed [EdgeWidth-1:0] edge_type;
   typedef logic signed [ProdWidth-1:0] prod_type;
   typedef logic signed [ProdWidth:0]   crs_type;
   typedef logic [HalfWidth-1:0]        half_type;
   typedef logic [2*HalfWidth-1:0]      part_type;
   typedef logic [2*CrossWidth-1:0]     csq_type;

   logic [6:0] vld_ff;
   edge_type   e1_ff [3], e2_ff [3];
   prod_type   pa_ff [3], pb_ff [3];
   crs_type    c_ff [3];
   cmag_type   cm_ff [3];
   half_type   ch [3], cl [3];
   part_type   hh_ff [3], hl_ff [3], ll_ff [3];
   csq_type    sq_ff [3], rho_ff [3];
   sq_type     s_ff;
   logic [2:0] neg4_ff, neg5_ff, neg6_ff, neg7_ff;
   logic       deg4_ff, deg5_ff, deg6_ff, deg7_ff;

   // valid bits per stage
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[5:0], in_valid};
      end
   end

   // stage 1: edges
   always_ff @(posedge clock) begin
      if (adv) begin
         e1_ff[0] <= EdgeWidth'(in_tri.v1_x) - EdgeWidth'(in_tri.v0_x);
         e1_ff[1] <= EdgeWidth'(in_tri.v1_y) - EdgeWidth'(in_tri.v0_y);
         e1_ff[2] <= EdgeWidth'(in_tri.v1_z) - EdgeWidth'(in_tri.v0_z);
         e2_ff[0] <= EdgeWidth'(in_tri.v2_x) - EdgeWidth'(in_tri.v0_x);
         e2_ff[1] <= EdgeWidth'(in_tri.v2_y) - EdgeWidth'(in_tri.v0_y);
         e2_ff[2] <= EdgeWidth'(in_tri.v2_z) - EdgeWidth'(in_tri.v0_z);
      end
   end

   // stage 2: six products, stage 3: differences
   always_ff @(posedge clock) begin
      if (adv) begin
         pa_ff[0] <= prod_type'(e1_ff[1]) * prod_type'(e2_ff[2]);
         pb_ff[0] <= prod_type'(e1_ff[2]) * prod_type'(e2_ff[1]);
         pa_ff[1] <= prod_type'(e1_ff[2]) * prod_type'(e2_ff[0]);
         pb_ff[1] <= prod_type'(e1_ff[0]) * prod_type'(e2_ff[2]);
         pa_ff[2] <= prod_type'(e1_ff[0]) * prod_type'(e2_ff[1]);
         pb_ff[2] <= prod_type'(e1_ff[1]) * prod_type'(e2_ff[0]);
         for (int i = 0; i < 3; i++) begin
            c_ff[i] <= (ProdWidth+1)'(pa_ff[i]) - (ProdWidth+1)'(pb_ff[i]);
         end
      end
   end

   // stage 4: magnitude and sign of each component (magnitude fits cross width)
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            cm_ff[i]   <= c_ff[i][ProdWidth] ? CrossWidth'(-c_ff[i]) : CrossWidth'(c_ff[i]);
            neg4_ff[i] <= c_ff[i][ProdWidth];
         end
         deg4_ff <= (c_ff[0] == '0) && (c_ff[1] == '0) && (c_ff[2] == '0);
      end
   end

   // halves of each magnitude for the squaring
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ch[i] = cm_ff[i][CrossWidth-1:HalfWidth];
         cl[i] = cm_ff[i][HalfWidth-1:0];
      end
   end

   // stage 5: half-width partial products
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            hh_ff[i] <= part_type'(ch[i]) * part_type'(ch[i]);
            hl_ff[i] <= part_type'(ch[i]) * part_type'(cl[i]);
            ll_ff[i] <= part_type'(cl[i]) * part_type'(cl[i]);
         end
         neg5_ff <= neg4_ff;
         deg5_ff <= deg4_ff;
      end
   end

   // stage 6: squares of each component
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= (csq_type'(hh_ff[i]) << (2 * HalfWidth))
                      + (csq_type'(hl_ff[i]) << (HalfWidth + 1))
                      + csq_type'(ll_ff[i]);
         end
         neg6_ff <= neg5_ff;
         deg6_ff <= deg5_ff;
      end
   end

   // stage 7: squared length
   always_ff @(posedge clock) begin
      if (adv) begin
         s_ff <= sq_type'(sq_ff[0]) + sq_type'(sq_ff[1]) + sq_type'(sq_ff[2]);
         for (int i = 0; i < 3; i++) begin
            rho_ff[i] <= sq_ff[i];
         end
         neg7_ff <= neg6_ff;
         deg7_ff <= deg6_ff;
      end
   end

   // output bundle to the root search
   always_comb begin
      out_valid = vld_ff[6];
      for (int i = 0; i < 3; i++) begin
         out_srch.rho[i]   = rho_type'(rho_ff[i]);
         out_srch.acc[i]   = '0;
         out_srch.root[i]  = '0;
         out_srch.c_neg[i] = neg7_ff[i];
      end
      out_srch.s          = s_ff;
      out_srch.degenerate = deg7_ff;
   end
endmodule

/* src/tfn_step.sv */
// one digit step of the scaled square-root search, registered
module tfn_step (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  tfn_pkg::srch_type  in_srch,
   output logic               out_valid,
   output tfn_pkg::srch_type  out_srch
);
   import tfn_pkg::*;

   logic     vld_ff;
   srch_type srch_ff;
   srch_type nxt;
   rho_type  trial;

   // set the next root bit when (4 * root + 1) * s fits in the remainder
   always_comb begin
      nxt = in_srch;
      for (int i = 0; i < 3; i++) begin
         trial = (in_srch.acc[i] << 2) + rho_type'(in_srch.s);
         if (trial <= in_srch.rho[i]) begin
            nxt.rho[i]  = (in_srch.rho[i] - trial) << 2;
            nxt.acc[i]  = (in_srch.acc[i] << 1) + rho_type'(in_srch.s);
            nxt.root[i] = {in_srch.root[i][RootWidth-2:0], 1'b1};
         end else begin
            nxt.rho[i]  = in_srch.rho[i] << 2;
            nxt.acc[i]  = in_srch.acc[i] << 1;
            nxt.root[i] = {in_srch.root[i][RootWidth-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         srch_ff <= nxt;
      end
   end

   assign out_valid = vld_ff;
   assign out_srch  = srch_ff;
endmodule

/* src/triangle_face_normal_core.sv */
// path from accepted beat to result: front pipeline, search step chain, then the output register
// throughput: one triangle per cycle while the output is not stalled, set by the fully pipelined search chain
// one root bit per stage of the search, shifts and adds only
// reset: synchronous, clears all valid bits; payload registers are not reset
// a stalled output holds the whole pipeline, nothing is lost or repeated
module triangle_face_normal_core (
   input logic clock,
   input logic reset,
   tfn_if.sink   req,
   tfn_if.source rsp
);
   import tfn_pkg::*;

   logic     adv;
   logic     v_chain [SearchSteps+1];
   srch_type s_chain [SearchSteps+1];
   logic     rsp_valid_ff;
   nrm_type  rsp_data_ff;
   nrm_type  rsp_data_in;
   q_type    q_mag [3];
   norm_type n_val [3];

   // pipeline moves when the output slot is free or being taken
   assign adv       = !rsp_valid_ff || rsp.ready;
   assign req.ready = adv;

   tfn_cross u_cross (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req.valid),
      .in_tri    (req.payload),
      .out_valid (v_chain[0]),
      .out_srch  (s_chain[0])
   );

   for (genvar g = 0; g < SearchSteps; g++) begin : g_step
      tfn_step u_step (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (v_chain[g]),
         .in_srch   (s_chain[g]),
         .out_valid (v_chain[g+1]),
         .out_srch  (s_chain[g+1])
      );
   end

   // round the root to the nearest output step (half steps round up), then sign and degenerate handling
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         q_mag[i] = q_type'(s_chain[SearchSteps].root[i][RootWidth-1:1])
                  + q_type'(s_chain[SearchSteps].root[i][0]);
         n_val[i] = s_chain[SearchSteps].c_neg[i] ? -norm_type'(q_mag[i])
                                                  :  norm_type'(q_mag[i]);
      end
      rsp_data_in.degenerate = s_chain[SearchSteps].degenerate;
      rsp_data_in.norm_x     = n_val[0];
      rsp_data_in.norm_y     = n_val[1];
      rsp_data_in.norm_z     = n_val[2];
      if (s_chain[SearchSteps].degenerate) begin
         rsp_data_in.norm_x = '0;
         rsp_data_in.norm_y = '0;
         rsp_data_in.norm_z = '0;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= v_chain[SearchSteps];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_data_ff;

   // a degenerate beat carries a zero normal
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.payload.degenerate |->
         rsp.payload.norm_x == '0 && rsp.payload.norm_y == '0 && rsp.payload.norm_z == '0)
      else $error("degenerate beat with nonzero normal");

   // a waiting beat is not overwritten by the pipeline
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.payload))
      else $error("pending result changed");

   // no acceptance while the output is blocked
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |-> !req.ready)
      else $error("input taken during stall");
endmodule
